FILE: design/lmcp_pkg.sv
// Shared types and constants for the layered minimum-cost path block.
package lmcp_pkg;
    localparam int MAX_LEGS   = 16;
    localparam int MAX_NODES  = 8;
    localparam int COST_WIDTH = 24;

    localparam int unsigned TOTAL_W = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic               ok;
        logic [TOTAL_W-1:0] dur;
        logic [TOTAL_W-1:0] distance;
    } t_cost;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction
endpackage

FILE: design/layered_min_cost_path.sv
// Top level: trellis load, backward min-sum pass and path readout.
// Each entry is stored into the cost memory. On the final entry the block
// runs a backward pass that reads one cost word per cycle through a
// registered memory read while it scans a node's successors, pausing to drain
// between nodes; the pass is paced by the single cost-memory read port. It
// then emits legs+1 words (one word if no path is found), one per cycle as the output is taken. No item is
// accepted during the pass.
module layered_min_cost_path
    import lmcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_leg,
    input  logic [2:0]  i_from_node,
    input  logic [2:0]  i_to_node,
    input  logic [23:0] i_leg_duration,
    input  logic [23:0] i_leg_distance,
    input  logic        i_reachable,
    input  logic        i_final_entry,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_waypoint,
    output logic [2:0]  o_chosen_node,
    output logic [31:0] o_total_duration,
    output logic [31:0] o_total_distance,
    output logic        o_found,
    output logic        o_last_result
);
    localparam int LW = $clog2(MAX_LEGS + 1);   // holds leg count 0..MAX_LEGS
    localparam int LI = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int NI = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NWP = MAX_LEGS + 1;
    localparam int DEPTH = MAX_LEGS * MAX_NODES * MAX_NODES;
    localparam int AW = $clog2(DEPTH);
    localparam int CAW = $clog2(NWP * MAX_NODES);
    localparam int CW = 2 * COST_WIDTH + 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [CW-1:0] cost_mem [DEPTH];
    logic [CW-1:0] r_rd;
    t_cost         tail_mem [2][MAX_NODES];
    logic [NI-1:0] choice_mem [NWP*MAX_NODES];

    logic [2:0]    r_state;
    logic [NW-1:0] r_cnt [NWP];
    logic [LW-1:0] r_legs;
    logic [LW-1:0] r_w;
    logic [NW-1:0] r_n, r_m;
    logic          r_pv;          // read issued last cycle
    logic [NI-1:0] r_pm;
    t_cost         r_best;
    logic [NI-1:0] r_choice;
    logic [NI-1:0] r_node;
    logic          r_out_valid;
    logic [4:0]    r_wp;

    wire in_ok = (32'(i_leg) < MAX_LEGS) && (32'(i_from_node) < MAX_NODES)
                 && (32'(i_to_node) < MAX_NODES);
    wire acc = i_valid && o_ready;
    assign o_ready = (r_state == S_LOAD);

    logic [LW-1:0] w_last;
    logic [LI-1:0] w_idx;
    assign w_last = r_legs - LW'(1);
    assign w_idx  = r_w[LI-1:0];

    logic [AW-1:0] wr_addr, rd_addr;
    assign wr_addr = AW'((32'(i_leg) * MAX_NODES + 32'(i_from_node)) * MAX_NODES
                     + 32'(i_to_node));
    assign rd_addr = AW'((32'(w_idx) * MAX_NODES + 32'(r_n)) * MAX_NODES + 32'(r_m));

    // candidate from the word read last cycle
    t_cost e, tl, c;
    logic  c_take;
    always_comb begin
        e.ok       = r_rd[CW-1];
        e.dur      = TOTAL_W'(r_rd[2*COST_WIDTH-1:COST_WIDTH]);
        e.distance = TOTAL_W'(r_rd[COST_WIDTH-1:0]);
        tl = tail_mem[~r_w[0]][r_pm];
        if (r_w == w_last) begin
            c = e;
        end else begin
            c.ok       = e.ok && tl.ok;
            c.dur      = sat_add(tl.dur, e.dur);
            c.distance = sat_add(tl.distance, e.distance);
        end
        c_take = r_pv && c.ok && (!r_best.ok || c.dur < r_best.dur);
    end

    wire n_live  = (r_n < r_cnt[r_w]) && (32'(r_n) < MAX_NODES);
    wire scan_rd = (r_state == S_SCAN) && n_live && (r_m < r_cnt[r_w + LW'(1)])
                   && (32'(r_m) < MAX_NODES);

    always_ff @(posedge i_clk) begin
        if (acc && in_ok) begin
            cost_mem[wr_addr] <= {i_reachable, i_leg_duration[COST_WIDTH-1:0],
                                  i_leg_distance[COST_WIDTH-1:0]};
        end
        r_rd <= cost_mem[rd_addr];
        r_pm <= r_m[NI-1:0];
        if (r_state == S_DRAIN && !r_pv) begin
            tail_mem[r_w[0]][r_n[NI-1:0]] <= r_best;
            choice_mem[CAW'(32'(w_idx) * MAX_NODES + 32'(r_n[NI-1:0]))] <= r_choice;
        end
        if (c_take) begin
            r_best   <= c;
            r_choice <= r_pm;
        end
        if (r_state == S_DRAIN && !r_pv) begin
            r_best.ok <= 1'b0;
            r_choice  <= '0;
        end
        if (r_state == S_START && r_n < r_cnt[0] && 32'(r_n) < MAX_NODES) begin
            if (tail_mem[0][r_n[NI-1:0]].ok && (!r_best.ok ||
                tail_mem[0][r_n[NI-1:0]].dur < r_best.dur)) begin
                r_best <= tail_mem[0][r_n[NI-1:0]];
                r_node <= r_n[NI-1:0];
            end
        end
        if (r_state == S_LOAD && acc && i_final_entry) begin
            r_best.ok <= 1'b0;
            r_choice  <= '0;
            r_node    <= '0;
        end
        if (r_state == S_OUT && o_valid && i_ready && !o_last_result) begin
            r_node <= choice_mem[CAW'(32'(o_waypoint[LI-1:0]) * MAX_NODES + 32'(r_node))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            for (int k = 0; k < NWP; k++) r_cnt[k] <= '0;
            r_legs <= '0;
            r_w <= '0; r_n <= '0; r_m <= '0;
            r_pv <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= scan_rd;
            unique case (r_state)
                S_LOAD: begin
                    if (acc && in_ok) begin
                        if (LW'(i_leg) + LW'(1) > r_legs) r_legs <= LW'(i_leg) + LW'(1);
                        if (NW'(i_from_node) + NW'(1) > r_cnt[LW'(i_leg)])
                            r_cnt[LW'(i_leg)] <= NW'(i_from_node) + NW'(1);
                        if (NW'(i_to_node) + NW'(1) > r_cnt[LW'(i_leg) + LW'(1)])
                            r_cnt[LW'(i_leg) + LW'(1)] <= NW'(i_to_node) + NW'(1);
                    end
                    if (acc && i_final_entry) begin
                        r_n <= '0; r_m <= '0;
                        if (!(acc && in_ok)) begin
                            r_w <= r_legs - LW'(1);
                            r_state <= (r_legs == '0) ? S_OUT : S_SCAN;
                        end else begin
                            r_w <= ((LW'(i_leg) + LW'(1) > r_legs) ? LW'(i_leg) + LW'(1)
                                    : r_legs) - LW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!n_live) begin
                        r_n <= '0;
                        if (r_w == '0) r_state <= S_START;
                        else r_w <= r_w - LW'(1);
                    end else if (scan_rd) begin
                        r_m <= r_m + NW'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_pv) begin
                        r_n <= r_n + NW'(1);
                        r_m <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_START: begin
                    if (r_n < r_cnt[0] && 32'(r_n) < MAX_NODES) r_n <= r_n + NW'(1);
                    else r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                    end else if (i_ready) begin
                        if (o_last_result) begin
                            r_out_valid <= 1'b0;
                            r_state <= S_LOAD;
                            r_legs <= '0;
                            for (int k = 0; k < NWP; k++) r_cnt[k] <= '0;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // output word
    wire found = r_best.ok && (r_legs != '0);
    always_ff @(posedge i_clk) begin
        if (r_state == S_START || r_state == S_LOAD) begin
            r_wp <= '0;
        end else if (r_state == S_OUT && o_valid && i_ready) begin
            r_wp <= r_wp + 5'd1;
        end
    end
    assign o_valid          = r_out_valid;
    assign o_waypoint       = r_wp;
    assign o_chosen_node    = found ? 3'(r_node) : 3'd0;
    assign o_total_duration = found ? r_best.dur : '0;
    assign o_total_distance = found ? r_best.distance : '0;
    assign o_found          = found;
    assign o_last_result    = !found || (o_waypoint == 5'(r_legs));
endmodule

FILE: design/lmcp_checker.sv
// Port-level checker for layered_min_cost_path, with its bind.
module lmcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_waypoint,
    input logic        o_found,
    input logic        o_last_result,
    input logic [31:0] o_total_duration
);
    ap_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken while results pending");
    ap_nf_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last_result && o_waypoint == 5'd0)
        else $error("not-found word malformed");
    ap_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_result |=> o_valid && o_waypoint == $past(o_waypoint) + 5'd1)
        else $error("waypoint sequence broken");
    ap_total_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_result |=> o_total_duration == $past(o_total_duration))
        else $error("total changed within run");
endmodule

bind layered_min_cost_path lmcp_checker u_lmcp_checker (.*);

FILE: dv/tb_layered_min_cost_path.sv
// Testbench for layered_min_cost_path: directed and random trellis runs checked against an in-bench predictor.
module tb_layered_min_cost_path;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEGS_MAX  = 16;
    localparam int NODES_MAX = 8;
    localparam int LIMIT     = 600000;

    localparam int CM_RANDOM = 0;
    localparam int CM_MAX    = 1;
    localparam int CM_ZERO   = 2;
    localparam int CM_TIES   = 3;

    typedef struct {
        logic [3:0]  leg;
        logic [2:0]  from_node;
        logic [2:0]  to_node;
        logic [23:0] dur;
        logic [23:0] distance;
        logic        reachable;
        logic        final_entry;
    } t_entry;

    typedef struct packed {
        logic [4:0]  waypoint;
        logic [2:0]  node;
        logic [31:0] dur;
        logic [31:0] distance;
        logic        found;
        logic        last;
    } t_waypoint;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready;
    logic [3:0]  i_leg;
    logic [2:0]  i_from_node, i_to_node;
    logic [23:0] i_leg_duration, i_leg_distance;
    logic        i_reachable, i_final_entry;
    logic        o_valid, i_ready;
    logic [4:0]  o_waypoint;
    logic [2:0]  o_chosen_node;
    logic [31:0] o_total_duration, o_total_distance;
    logic        o_found, o_last_result;

    layered_min_cost_path dut (.*);

    // trellis mirror
    logic [23:0] trel_dur [LEGS_MAX*NODES_MAX*NODES_MAX];
    logic [23:0] trel_dist[LEGS_MAX*NODES_MAX*NODES_MAX];
    logic        trel_ok  [LEGS_MAX*NODES_MAX*NODES_MAX];
    bit          trel_seen[LEGS_MAX*NODES_MAX*NODES_MAX];
    int          wp_nodes [LEGS_MAX+1];
    int          leg_total;

    t_entry    entry_q[$];
    t_waypoint path_q[$];

    int cycles, accepted, words_seen, mismatches, runs, found_runs, lost_runs;
    int phase, hold_cnt;
    bit hold_done;

    function automatic logic [31:0] add_clip(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic int cell_idx(int l, int f, int t);
        return (l * NODES_MAX + f) * NODES_MAX + t;
    endfunction

    task automatic solve_trellis();
        logic        t_ok  [2][NODES_MAX];
        logic [31:0] t_dur [2][NODES_MAX];
        logic [31:0] t_dist[2][NODES_MAX];
        int          succ[(LEGS_MAX+1)*NODES_MAX];
        logic        b_ok, c_ok;
        logic [31:0] b_dur, b_dist, c_dur, c_dist;
        int          row, nrow, pick, start, n, ci;
        t_waypoint   r;
        start = 0;
        for (int w = leg_total - 1; w >= 0; w--) begin
            row = w & 1;
            nrow = row ^ 1;
            for (int a = 0; a < wp_nodes[w]; a++) begin
                b_ok = 0; b_dur = 0; b_dist = 0; pick = 0;
                for (int m = 0; m < wp_nodes[w+1]; m++) begin
                    ci = cell_idx(w, a, m);
                    if (!trel_ok[ci]) continue;
                    if (w == leg_total - 1) begin
                        c_dur = trel_dur[ci];
                        c_dist = trel_dist[ci];
                    end else begin
                        if (!t_ok[nrow][m]) continue;
                        c_dur = add_clip(t_dur[nrow][m], trel_dur[ci]);
                        c_dist = add_clip(t_dist[nrow][m], trel_dist[ci]);
                    end
                    if (!b_ok || c_dur < b_dur) begin
                        b_ok = 1; b_dur = c_dur; b_dist = c_dist; pick = m;
                    end
                end
                t_ok[row][a] = b_ok; t_dur[row][a] = b_dur; t_dist[row][a] = b_dist;
                succ[w*NODES_MAX + a] = pick;
            end
        end
        b_ok = 0; b_dur = 0; b_dist = 0;
        for (int a = 0; a < wp_nodes[0]; a++) begin
            if (t_ok[0][a] && (!b_ok || t_dur[0][a] < b_dur)) begin
                b_ok = 1; b_dur = t_dur[0][a]; b_dist = t_dist[0][a]; start = a;
            end
        end
        runs++;
        if (leg_total == 0 || !b_ok) begin
            lost_runs++;
            r = '{5'd0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1};
            path_q = {path_q, r};
        end else begin
            found_runs++;
            n = start;
            for (int k = 0; k <= leg_total; k++) begin
                r = '{k[4:0], n[2:0], b_dur, b_dist, 1'b1, k == leg_total};
                path_q = {path_q, r};
                if (k < leg_total) n = succ[k*NODES_MAX + n];
            end
        end
    endtask

    task automatic load_entry(t_entry e);
        int ci;
        ci = cell_idx(e.leg, e.from_node, e.to_node);
        trel_dur[ci] = e.dur; trel_dist[ci] = e.distance; trel_ok[ci] = e.reachable;
        trel_seen[ci] = 1;
        if (e.leg + 1 > leg_total) leg_total = e.leg + 1;
        if (e.from_node + 1 > wp_nodes[e.leg]) wp_nodes[e.leg] = e.from_node + 1;
        if (e.to_node + 1 > wp_nodes[e.leg+1]) wp_nodes[e.leg+1] = e.to_node + 1;
        entry_q = {entry_q, e};
        if (e.final_entry) begin
            solve_trellis();
            foreach (wp_nodes[i]) wp_nodes[i] = 0;
            leg_total = 0;
        end
    endtask

    // cost_mode: random, all max, all zero, or few values (ties)
    task automatic build_run(int legs, int max_nodes, int reach_pct, int cost_mode);
        int     cnt[LEGS_MAX+1];
        int     cells[$];
        int     keep[$];
        int     j, tmp, ci;
        t_entry e;
        for (int w = 0; w <= legs; w++) cnt[w] = $urandom_range(max_nodes, 1);
        for (int w = 0; w < legs; w++)
            for (int a = 0; a < cnt[w]; a++)
                for (int m = 0; m < cnt[w+1]; m++) cells = {cells, cell_idx(w, a, m)};
        for (int i = cells.size() - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            tmp = cells[i]; cells[i] = cells[j]; cells[j] = tmp;
        end
        foreach (cells[i])
            if (!trel_seen[cells[i]] || $urandom_range(1, 0) || i == cells.size() - 1)
                keep = {keep, cells[i]};
        foreach (keep[i]) begin
            ci = keep[i];
            e.leg = 4'(ci / (NODES_MAX*NODES_MAX));
            e.from_node = 3'((ci / NODES_MAX) % NODES_MAX);
            e.to_node = 3'(ci % NODES_MAX);
            case (cost_mode)
                CM_MAX: begin e.dur = '1; e.distance = '1; end
                CM_ZERO: begin e.dur = '0; e.distance = '0; end
                CM_TIES: begin e.dur = 24'($urandom_range(2, 0)); e.distance = 24'($urandom); end
                default: begin e.dur = 24'($urandom); e.distance = 24'($urandom); end
            endcase
            e.reachable = $urandom_range(99, 0) < reach_pct;
            e.final_entry = (i == keep.size() - 1);
            load_entry(e);
        end
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && o_ready) accepted++;
            if (!i_valid || o_ready) begin
                if (entry_q.size() > 0 &&
                    !((phase == 1 || phase == 3) &&
                      $urandom_range(99, 0) < (phase == 1 ? 74 : 18))) begin
                    i_leg <= entry_q[0].leg;
                    i_from_node <= entry_q[0].from_node;
                    i_to_node <= entry_q[0].to_node;
                    i_leg_duration <= entry_q[0].dur;
                    i_leg_distance <= entry_q[0].distance;
                    i_reachable <= entry_q[0].reachable;
                    i_final_entry <= entry_q[0].final_entry;
                    void'(entry_q.pop_front());
                    i_valid <= 1;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // long receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (!hold_done && accepted > 200 && o_valid) begin
            hold_done <= 1;
            hold_cnt <= 3000;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_waypoint x, got;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            cycles++;
            phase <= (accepted / 60) % 4;
            if (o_valid && i_ready) begin
                words_seen++;
                got = '{o_waypoint, o_chosen_node, o_total_duration, o_total_distance,
                        o_found, o_last_result};
                if (path_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word: wp %0d", o_waypoint);
                end else begin
                    x = path_q.pop_front();
                    if (got != x) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp wp %0d node %0d dur %0d dist %0d f %0b l %0b",
                                     x.waypoint, x.node, x.dur, x.distance, x.found, x.last);
                            $display("          got wp %0d node %0d dur %0d dist %0d f %0b l %0b",
                                     got.waypoint, got.node, got.dur, got.distance, got.found,
                                     got.last);
                        end
                    end
                end
            end
            if (hold_cnt > 0 || (!hold_done && accepted > 200 && o_valid)) begin
                i_ready <= 0;
            end else begin
                i_ready <= !((phase == 2 || phase == 3) &&
                             $urandom_range(99, 0) < (phase == 2 ? 74 : 18));
            end
            if (cycles > LIMIT) begin
                $display("timeout");
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int lg;
        i_rst_n = 0; i_valid = 0; i_ready = 0;
        i_leg = 0; i_from_node = 0; i_to_node = 0;
        i_leg_duration = 0; i_leg_distance = 0; i_reachable = 0; i_final_entry = 0;
        cycles = 0; accepted = 0; words_seen = 0; mismatches = 0;
        runs = 0; found_runs = 0; lost_runs = 0; phase = 0; hold_done = 0;
        foreach (trel_seen[i]) trel_seen[i] = 0;
        foreach (wp_nodes[i]) wp_nodes[i] = 0;
        leg_total = 0;
        // directed runs
        build_run(1, 1, 100, CM_MAX);
        build_run(1, 1, 100, CM_ZERO);
        build_run(2, 2, 0, CM_RANDOM);
        build_run(2, 3, 100, CM_TIES);
        build_run(2, 3, 100, CM_TIES);
        build_run(1, 2, 50, CM_MAX);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        // random runs, mostly small, a few large
        while (accepted + entry_q.size() < 240) begin
            lg = $urandom_range(99, 0) < 85 ? $urandom_range(4, 1) : $urandom_range(16, 5);
            build_run(lg, lg > 4 ? 2 : $urandom_range(NODES_MAX, 1),
                      $urandom_range(1, 0) ? 90 : 45,
                      $urandom_range(9, 0) < 2 ? CM_TIES : CM_RANDOM);
            wait (entry_q.size() < 40);
        end
        build_run(16, 2, 95, CM_MAX);
        build_run(2, 8, 90, CM_RANDOM);
        wait (entry_q.size() == 0 && path_q.size() == 0);
        repeat (2000) @(posedge i_clk);
        $display("%0d entries, %0d trellis runs (%0d with a path, %0d without), %0d words",
                 accepted, runs, found_runs, lost_runs, words_seen);
        $display("%0d mismatches, %0d words still expected", mismatches, path_q.size());
        if (mismatches == 0 && path_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
